// ===== rtl/rlt_pkg.sv =====
// Shared constants, codes and helper functions for the level residency tracker.
// Used by rlt_ram, level_residency_tracker and rlt_checker; depends on nothing.
package rlt_pkg;

  localparam int DOMAINS = 8;
  localparam int LEVELS = 16;

  localparam int DOM_W = 3;
  localparam int LVL_W = 4;
  localparam int DOM_SLOTS = 1 << DOM_W;
  localparam int SLOT_W = DOM_W + LVL_W;
  localparam int STORE_DEPTH = 1 << SLOT_W;

  localparam int CNT_FIELD_W = 5;
  localparam int LEVEL_COUNTS_W = CNT_FIELD_W * DOM_SLOTS;
  localparam int CFG_W = LEVEL_COUNTS_W;
  localparam int CFG_IDX_W = 1;

  localparam int TIME_W = 64;
  localparam int ENTRY_W = 32;

  localparam logic [CNT_FIELD_W-1:0] LEVELS_CNT = CNT_FIELD_W'(LEVELS);

  // Request modes.
  localparam logic [1:0] MODE_CHANGE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_UNTRACKED = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 1'd1;

  // Level count of one domain, saturated at LEVELS.
  function automatic logic [CNT_FIELD_W-1:0] count_of(
    input logic [LEVEL_COUNTS_W-1:0] lc,
    input logic [DOM_W-1:0] dom
  );
    logic [CNT_FIELD_W-1:0] c;
    c = lc[CNT_FIELD_W*dom +: CNT_FIELD_W];
    if (c > LEVELS_CNT) begin
      c = LEVELS_CNT;
    end
    return c;
  endfunction

  // Store address of a (domain, level) entry.
  function automatic logic [SLOT_W-1:0] slot_of(
    input logic [DOM_W-1:0] dom,
    input logic [LVL_W-1:0] lvl
  );
    return {dom, lvl};
  endfunction

endpackage

// ===== rtl/rlt_ram.sv =====
// Single-port-write, single-port-read store with a registered read.
// Per-entry valid bits make never-written entries read as zero after reset; uses rlt_pkg.
module rlt_ram #(
  parameter int WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [rlt_pkg::SLOT_W-1:0] waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [rlt_pkg::SLOT_W-1:0] raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [rlt_pkg::STORE_DEPTH];
  logic [rlt_pkg::STORE_DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_mem;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_mem <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_mem : '0;

endmodule

// ===== rtl/level_residency_tracker.sv =====
// Top level of the level residency tracker: request sequencer, domain registers,
// configuration registers and result register. Depends on rlt_pkg and rlt_ram.

// Keeps residency time and entry counts for every (domain, level) pair. A level
// change request adds the time since the domain's last change to the level being
// left, counts one entry into the new level and records the new level and time.
// A tick request accrues time for the current level of every tracked domain. A
// read request returns the two counters of one entry. Both counter stores live
// in synchronous memories with a registered read; the residency store is read,
// modified and written back once per update, the entry-count store once per
// level change. An accepted change, read or rejected request goes to the
// finishing state, which loads the result register once the result channel
// is free; the next request can be taken after that. An accepted tick walks every
// domain in the tick state, one residency memory pass per tracked domain issued
// back to back with the previous write-back, then finishes the same way. The
// counter stores start cleared right after reset with no clearing pass. A new
// request is accepted while a finished result waits in the result register;
// its own result waits in the finishing state until the older one is taken. The
// user must write configuration only while idle; the block does not enforce it.
module level_residency_tracker (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel.
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          mode,
  input  logic [rlt_pkg::DOM_W-1:0]           domain,
  input  logic [rlt_pkg::LVL_W-1:0]           level,
  input  logic [rlt_pkg::TIME_W-1:0]          now_us,
  // Result channel.
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          status,
  output logic [rlt_pkg::TIME_W-1:0]          residency_us,
  output logic [rlt_pkg::ENTRY_W-1:0]         entry_count,
  output logic [rlt_pkg::LVL_W-1:0]           current_level,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [rlt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlt_pkg::CFG_W-1:0]           cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [rlt_pkg::DOM_W-1:0] LAST_DOM = rlt_pkg::DOM_W'(rlt_pkg::DOMAINS - 1);

  logic [1:0] state;
  logic [rlt_pkg::DOM_W-1:0] walk_d;

  // Configuration registers.
  logic stats_enable;
  logic [rlt_pkg::LEVEL_COUNTS_W-1:0] level_counts;

  // Per-domain state.
  logic [rlt_pkg::LVL_W-1:0]  cur_lvl   [rlt_pkg::DOM_SLOTS];
  logic [rlt_pkg::TIME_W-1:0] last_time [rlt_pkg::DOM_SLOTS];

  // Request held while it is worked on.
  logic [1:0] op_mode;
  logic [1:0] op_status;
  logic [rlt_pkg::LVL_W-1:0] op_cl;
  logic [rlt_pkg::TIME_W-1:0] now_q;

  // Write-back stage: one read-modify-write issued in the previous cycle.
  logic wb_v;
  logic wb_cnt_en;
  logic wb_set_lvl;
  logic [rlt_pkg::DOM_W-1:0] wb_dom;
  logic [rlt_pkg::LVL_W-1:0] wb_lvl;
  logic [rlt_pkg::SLOT_W-1:0] wb_res_slot;
  logic [rlt_pkg::SLOT_W-1:0] wb_cnt_slot;
  logic [rlt_pkg::TIME_W-1:0] wb_delta;
  logic [rlt_pkg::TIME_W-1:0] wb_now;

  // Memory ports.
  logic res_re;
  logic [rlt_pkg::SLOT_W-1:0] res_raddr;
  logic [rlt_pkg::TIME_W-1:0] res_rdata;
  logic cnt_re;
  logic [rlt_pkg::ENTRY_W-1:0] cnt_rdata;

  // Request decode.
  logic accept;
  logic [rlt_pkg::CNT_FIELD_W-1:0] req_cnt;
  logic dom_in_range;
  logic dom_ok;
  logic lvl_ok;
  logic [1:0] status_new;
  logic [rlt_pkg::DOM_W-1:0] cur_idx;
  logic [rlt_pkg::LVL_W-1:0] cur_sel;
  logic [rlt_pkg::TIME_W-1:0] last_sel;
  logic [rlt_pkg::TIME_W-1:0] now_sel;
  logic issue_change;
  logic issue_tick;
  logic issue_read;
  logic issue;
  logic out_free;

  assign req_stall = (state != S_IDLE);
  assign accept = req_valid && (state == S_IDLE);
  assign out_free = !res_valid || !res_stall;

  assign req_cnt = rlt_pkg::count_of(level_counts, domain);
  assign dom_in_range = (int'(domain) < rlt_pkg::DOMAINS);
  assign dom_ok = dom_in_range && (req_cnt != '0);
  assign lvl_ok = ({1'b0, level} < req_cnt);

  // Checks per mode, in order: change enable, domain, level; tick enable only; read domain, level.
  always_comb begin
    case (mode)
      rlt_pkg::MODE_CHANGE: begin
        if (!stats_enable) status_new = rlt_pkg::ST_DISABLED;
        else if (!dom_ok) status_new = rlt_pkg::ST_UNTRACKED;
        else if (!lvl_ok) status_new = rlt_pkg::ST_RANGE;
        else status_new = rlt_pkg::ST_OK;
      end
      rlt_pkg::MODE_TICK: begin
        status_new = stats_enable ? rlt_pkg::ST_OK : rlt_pkg::ST_DISABLED;
      end
      rlt_pkg::MODE_READ: begin
        if (!dom_ok) status_new = rlt_pkg::ST_UNTRACKED;
        else if (!lvl_ok) status_new = rlt_pkg::ST_RANGE;
        else status_new = rlt_pkg::ST_OK;
      end
      default: begin
        status_new = rlt_pkg::ST_OK;
      end
    endcase
  end

  // The domain registers are looked up at one place: the request's domain while
  // idle, the walking domain during a tick.
  assign cur_idx = (state == S_TICK) ? walk_d : domain;
  assign cur_sel = cur_lvl[cur_idx];
  assign last_sel = last_time[cur_idx];
  assign now_sel = (state == S_TICK) ? now_q : now_us;

  assign issue_change = accept && (mode == rlt_pkg::MODE_CHANGE) && (status_new == rlt_pkg::ST_OK);
  assign issue_read = accept && (mode == rlt_pkg::MODE_READ) && (status_new == rlt_pkg::ST_OK);
  assign issue_tick = (state == S_TICK) && (rlt_pkg::count_of(level_counts, walk_d) != '0);
  assign issue = issue_change || issue_tick;

  // The residency memory is read at the entry being left (change, tick) or at
  // the entry asked for (read); the entry-count memory at the new or read entry.
  assign res_re = issue || issue_read;
  assign res_raddr = issue_read ? rlt_pkg::slot_of(domain, level)
                                : rlt_pkg::slot_of(cur_idx, cur_sel);
  assign cnt_re = issue_change || issue_read;

  rlt_ram #(
    .WIDTH(rlt_pkg::TIME_W)
  ) u_res_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (wb_v),
    .waddr (wb_res_slot),
    .wdata (res_rdata + wb_delta),
    .re    (res_re),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  rlt_ram #(
    .WIDTH(rlt_pkg::ENTRY_W)
  ) u_cnt_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (wb_v && wb_cnt_en),
    .waddr (wb_cnt_slot),
    .wdata (cnt_rdata + rlt_pkg::ENTRY_W'(1)),
    .re    (cnt_re),
    .raddr (rlt_pkg::slot_of(domain, level)),
    .rdata (cnt_rdata)
  );

  // Issue stage payload. The time difference is taken here so the write-back
  // only has one add in front of the memory.
  always_ff @(posedge clk) begin
    if (issue) begin
      wb_dom      <= cur_idx;
      wb_lvl      <= level;
      wb_cnt_en   <= issue_change;
      wb_set_lvl  <= issue_change;
      wb_res_slot <= rlt_pkg::slot_of(cur_idx, cur_sel);
      wb_cnt_slot <= rlt_pkg::slot_of(domain, level);
      wb_delta    <= now_sel - last_sel;
      wb_now      <= now_sel;
    end
    if (accept) begin
      op_mode   <= mode;
      op_status <= status_new;
      now_q     <= now_us;
      if (issue_change) begin
        op_cl <= level;
      end else begin
        op_cl <= dom_in_range ? cur_sel : '0;
      end
    end
  end

  // Control, configuration and domain registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      walk_d       <= '0;
      wb_v         <= 1'b0;
      res_valid    <= 1'b0;
      stats_enable <= 1'b0;
      level_counts <= '0;
      for (int i = 0; i < rlt_pkg::DOM_SLOTS; i++) begin
        cur_lvl[i]   <= '0;
        last_time[i] <= '0;
      end
    end else begin
      wb_v <= issue;

      if (cfg_we) begin
        case (cfg_index)
          rlt_pkg::CFG_ENABLE: stats_enable <= cfg_data[0];
          rlt_pkg::CFG_LEVELS: level_counts <= cfg_data[rlt_pkg::LEVEL_COUNTS_W-1:0];
          default: ;
        endcase
      end

      // Write-back of the domain registers goes with the memory write.
      if (wb_v) begin
        last_time[wb_dom] <= wb_now;
        if (wb_set_lvl) begin
          cur_lvl[wb_dom] <= wb_lvl;
        end
      end

      // A finished request refills the result register in the same cycle that
      // the waiting result is taken.
      if ((state == S_FIN) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            walk_d <= '0;
            if ((mode == rlt_pkg::MODE_TICK) && (status_new == rlt_pkg::ST_OK)) begin
              state <= S_TICK;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_TICK: begin
          if (walk_d == LAST_DOM) begin
            state <= S_FIN;
          end else begin
            walk_d <= walk_d + rlt_pkg::DOM_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register. Read data stays in the memory output registers while the
  // result waits, since no read is issued in the finishing state.
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      status        <= op_status;
      current_level <= op_cl;
      if ((op_mode == rlt_pkg::MODE_READ) && (op_status == rlt_pkg::ST_OK)) begin
        residency_us <= res_rdata;
        entry_count  <= cnt_rdata;
      end else begin
        residency_us <= '0;
        entry_count  <= '0;
      end
    end
  end

endmodule

// ===== rtl/rlt_checker.sv =====
// Port-level checks for the level residency tracker, bound to its top level.
// Depends on rlt_pkg and level_residency_tracker.
module rlt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic [1:0]                  status,
  input logic [rlt_pkg::TIME_W-1:0]  residency_us,
  input logic [rlt_pkg::ENTRY_W-1:0] entry_count
);

  // A waiting result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(residency_us)
      && $stable(entry_count))
    else $error("result changed while stalled");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // A new result only appears at the end of a request's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result without a request in progress");

  // Rejected requests report zero counters.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != rlt_pkg::ST_OK) |-> (residency_us == '0) && (entry_count == '0))
    else $error("counters reported on a rejected request");

endmodule

bind level_residency_tracker rlt_checker u_rlt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .status       (status),
  .residency_us (residency_us),
  .entry_count  (entry_count)
);

// ===== verif/tb.sv =====
// Self-checking testbench for level_residency_tracker: directed table, then random phases.
// Depends on rlt_pkg and the level_residency_tracker RTL; predicts every result locally.
`timescale 1ns / 1ps

module tb;

  // Mode 3 has no meaning in the block; it must answer with an empty ok result.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles allowed after the last result before idle work or the end.
  localparam int SETTLE_CYCLES = 12;

  // Cycles with no request or result accepted before the run is declared hung.
  localparam int HANG_LIMIT = 5000;

  // Mismatch lines printed before further ones are only counted.
  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [1:0]                  status;
    logic [rlt_pkg::TIME_W-1:0]  residency;
    logic [rlt_pkg::ENTRY_W-1:0] entries;
    logic [rlt_pkg::LVL_W-1:0]   cur;
  } result_t;

  // One line of the directed plan: either a register write or a request.
  typedef struct packed {
    bit                            is_cfg;
    logic [rlt_pkg::CFG_IDX_W-1:0] idx;
    logic [rlt_pkg::CFG_W-1:0]     data;
    logic [1:0]                    mode;
    logic [rlt_pkg::DOM_W-1:0]     dom;
    logic [rlt_pkg::LVL_W-1:0]     lvl;
    logic [rlt_pkg::TIME_W-1:0]    now;
    bit                            fixed;
    result_t                       want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [1:0]                    mode = rlt_pkg::MODE_CHANGE;
  logic [rlt_pkg::DOM_W-1:0]     domain = '0;
  logic [rlt_pkg::LVL_W-1:0]     level = '0;
  logic [rlt_pkg::TIME_W-1:0]    now_us = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic [1:0]                    status;
  logic [rlt_pkg::TIME_W-1:0]    residency_us;
  logic [rlt_pkg::ENTRY_W-1:0]   entry_count;
  logic [rlt_pkg::LVL_W-1:0]     current_level;
  logic                          cfg_we = 1'b0;
  logic [rlt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rlt_pkg::CFG_W-1:0]     cfg_data = '0;

  level_residency_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .domain        (domain),
    .level         (level),
    .now_us        (now_us),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .residency_us  (residency_us),
    .entry_count   (entry_count),
    .current_level (current_level),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Local tracker state, advanced once per accepted request, and local configuration.
  logic [rlt_pkg::TIME_W-1:0]  pr_residency [0:rlt_pkg::STORE_DEPTH-1];
  logic [rlt_pkg::ENTRY_W-1:0] pr_entries [0:rlt_pkg::STORE_DEPTH-1];
  logic [rlt_pkg::LVL_W-1:0]   pr_level [0:rlt_pkg::DOM_SLOTS-1];
  logic [rlt_pkg::TIME_W-1:0]  pr_last [0:rlt_pkg::DOM_SLOTS-1];
  logic                        pr_enable = 1'b0;
  logic [rlt_pkg::CFG_W-1:0]   pr_counts = '0;

  // Results predicted for accepted requests, oldest first.
  result_t due_results[$];

  int errors = 0;
  int results_checked = 0;
  int settings_written = 0;
  int n_mode [0:3];
  int n_status [0:3];
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_style = 0;

  // Number of usable levels of a domain; counts above LEVELS saturate, zero means untracked.
  function automatic int unsigned level_limit(input int unsigned d);
    logic [rlt_pkg::CNT_FIELD_W-1:0] c;
    c = pr_counts[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W];
    return (c > rlt_pkg::LEVELS) ? rlt_pkg::LEVELS : int'(c);
  endfunction

  // Adds the time since the domain's last change to its current level and restarts the clock.
  // The subtraction wraps when time runs backwards, as the hardware counters do.
  function automatic void accrue_level_time(input int unsigned d,
                                            input logic [rlt_pkg::TIME_W-1:0] t);
    int unsigned slot;
    slot = d * 16 + pr_level[d];
    pr_residency[slot] = pr_residency[slot] + (t - pr_last[d]);
    pr_last[d] = t;
  endfunction

  // Computes the result of one request and updates the local state as the block would.
  function automatic result_t residency_predict(input logic [1:0] m,
                                                input logic [rlt_pkg::DOM_W-1:0] d,
                                                input logic [rlt_pkg::LVL_W-1:0] l,
                                                input logic [rlt_pkg::TIME_W-1:0] t);
    result_t r;
    int unsigned lim;
    int unsigned k;
    r = '0;
    lim = (d < rlt_pkg::DOMAINS) ? level_limit(d) : 0;
    case (m)
      rlt_pkg::MODE_CHANGE: begin
        // Enable is checked first, then the domain, then the level.
        if (!pr_enable) begin
          r.status = rlt_pkg::ST_DISABLED;
        end else if (lim == 0) begin
          r.status = rlt_pkg::ST_UNTRACKED;
        end else if (l >= lim) begin
          r.status = rlt_pkg::ST_RANGE;
        end else begin
          accrue_level_time(d, t);
          pr_entries[d * 16 + l] = pr_entries[d * 16 + l] + 1;
          pr_level[d] = l;
        end
      end
      rlt_pkg::MODE_TICK: begin
        // A tick ignores the domain field and walks every tracked domain.
        if (!pr_enable) begin
          r.status = rlt_pkg::ST_DISABLED;
        end else begin
          for (k = 0; k < rlt_pkg::DOMAINS; k++) begin
            if (level_limit(k) != 0) begin
              accrue_level_time(k, t);
            end
          end
        end
      end
      rlt_pkg::MODE_READ: begin
        // Reads work whether or not the block is enabled.
        if (lim == 0) begin
          r.status = rlt_pkg::ST_UNTRACKED;
        end else if (l >= lim) begin
          r.status = rlt_pkg::ST_RANGE;
        end else begin
          r.residency = pr_residency[d * 16 + l];
          r.entries = pr_entries[d * 16 + l];
        end
      end
      default: begin
      end
    endcase
    r.cur = (d < rlt_pkg::DOMAINS) ? pr_level[d] : '0;
    return r;
  endfunction

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(input string what, input logic [rlt_pkg::TIME_W-1:0] got,
                                 input logic [rlt_pkg::TIME_W-1:0] want);
    if (errors < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Result side: every accepted result is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    result_t w;
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request pending, status",
                        rlt_pkg::TIME_W'(status), '0);
      end else begin
        w = due_results.pop_front();
        if (status !== w.status) begin
          report_mismatch("status", rlt_pkg::TIME_W'(status), rlt_pkg::TIME_W'(w.status));
        end
        if (residency_us !== w.residency) begin
          report_mismatch("residency_us", residency_us, w.residency);
        end
        if (entry_count !== w.entries) begin
          report_mismatch("entry_count", rlt_pkg::TIME_W'(entry_count),
                          rlt_pkg::TIME_W'(w.entries));
        end
        if (current_level !== w.cur) begin
          report_mismatch("current_level", rlt_pkg::TIME_W'(current_level),
                          rlt_pkg::TIME_W'(w.cur));
        end
        results_checked++;
      end
    end
  end

  // The receiver switches its stall style after each run of random length: none, light
  // random, alternating, or heavy random.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_style)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ~res_stall;
        default: res_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Hang detection: only cycles in which neither channel moves anything are counted.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", HANG_LIMIT);
        $display("level_residency_tracker test failed");
        $finish;
      end
    end
  end

  // Presents one request from a falling edge, holds it until accepted, predicts its result
  // and returns at the next falling edge. The valid line is left high for the caller.
  task automatic issue(input logic [1:0] m, input logic [rlt_pkg::DOM_W-1:0] d,
                       input logic [rlt_pkg::LVL_W-1:0] l,
                       input logic [rlt_pkg::TIME_W-1:0] t,
                       input bit fixed, input result_t fixed_want);
    result_t r;
    req_valid <= 1'b1;
    mode <= m;
    domain <= d;
    level <= l;
    now_us <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = residency_predict(m, d, l, t);
    due_results.push_back(fixed ? fixed_want : r);
    n_mode[m]++;
    n_status[r.status]++;
    @(negedge clk);
  endtask

  // Lowers valid and waits for every outstanding result, then lets the block settle.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register from a falling edge; the local configuration follows at once.
  task automatic cfg_write(input logic [rlt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlt_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rlt_pkg::CFG_ENABLE) begin
      pr_enable = data[0];
    end else begin
      pr_counts = data;
    end
    settings_written++;
    @(negedge clk);
  endtask

  // Per-domain level counts drawn so that untracked, single-level, full and saturating
  // domains all turn up.
  function automatic logic [rlt_pkg::CFG_W-1:0] random_level_counts();
    logic [rlt_pkg::CFG_W-1:0] c;
    int unsigned r;
    int unsigned d;
    c = '0;
    for (d = 0; d < rlt_pkg::DOM_SLOTS; d++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: c[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W] = 5'd0;
        1: c[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W] = 5'd1;
        2: c[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W] = 5'd16;
        3: c[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W] = 5'($urandom_range(17, 31));
        default: c[rlt_pkg::CNT_FIELD_W*d +: rlt_pkg::CNT_FIELD_W] = 5'($urandom_range(1, 16));
      endcase
    end
    return c;
  endfunction

  plan_row_t plan[$];

  task automatic plan_cfg(input logic [rlt_pkg::CFG_IDX_W-1:0] idx,
                          input logic [rlt_pkg::CFG_W-1:0] data);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = data;
    plan.push_back(p);
  endtask

  // A request checked against the predictor.
  task automatic plan_req(input logic [1:0] m, input logic [rlt_pkg::DOM_W-1:0] d,
                          input logic [rlt_pkg::LVL_W-1:0] l,
                          input logic [rlt_pkg::TIME_W-1:0] t);
    plan_row_t p;
    p = '0;
    p.mode = m;
    p.dom = d;
    p.lvl = l;
    p.now = t;
    plan.push_back(p);
  endtask

  // A request whose result is typed in by hand.
  task automatic plan_fixed(input logic [1:0] m, input logic [rlt_pkg::DOM_W-1:0] d,
                            input logic [rlt_pkg::LVL_W-1:0] l,
                            input logic [rlt_pkg::TIME_W-1:0] t,
                            input logic [1:0] st, input logic [rlt_pkg::LVL_W-1:0] cur);
    plan_row_t p;
    p = '0;
    p.mode = m;
    p.dom = d;
    p.lvl = l;
    p.now = t;
    p.fixed = 1'b1;
    p.want.status = st;
    p.want.cur = cur;
    plan.push_back(p);
  endtask

  initial begin
    plan_row_t row;
    logic [rlt_pkg::CFG_W-1:0] mixed_counts;
    logic [rlt_pkg::CFG_W-1:0] narrow_counts;
    logic [rlt_pkg::CFG_W-1:0] counts;
    logic [rlt_pkg::TIME_W-1:0] clock_us;
    logic [1:0] m;
    logic [rlt_pkg::DOM_W-1:0] d;
    logic [rlt_pkg::LVL_W-1:0] l;
    logic en;
    int unsigned lim;
    int unsigned r;
    int n_items;
    int burst_left;
    int ph;
    int i;
    int k;

    for (i = 0; i < rlt_pkg::STORE_DEPTH; i++) begin
      pr_residency[i] = '0;
      pr_entries[i] = '0;
    end
    for (i = 0; i < rlt_pkg::DOM_SLOTS; i++) begin
      pr_level[i] = '0;
      pr_last[i] = '0;
      n_mode[i % 4] = 0;
      n_status[i % 4] = 0;
    end

    // Counts from domain 7 down to domain 0: 16, 5, 17 (saturates), 2, 0 (untracked),
    // 31 (saturates), 1, 16.
    mixed_counts = {5'd16, 5'd5, 5'd17, 5'd2, 5'd0, 5'd31, 5'd1, 5'd16};
    // Same, but domain 2 shrinks to two levels while it sits at level 3.
    narrow_counts = {5'd16, 5'd5, 5'd17, 5'd2, 5'd0, 5'd2, 5'd1, 5'd16};

    // Straight out of reset: nothing tracked and nothing enabled.
    plan_fixed(rlt_pkg::MODE_READ, 3'd0, 4'd0, 64'd0, rlt_pkg::ST_UNTRACKED, 4'd0);
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd0, 4'd0, 64'd0, rlt_pkg::ST_DISABLED, 4'd0);
    plan_fixed(rlt_pkg::MODE_TICK, 3'd5, 4'd15, '1, rlt_pkg::ST_DISABLED, 4'd0);
    plan_fixed(MODE_UNUSED, 3'd7, 4'd15, '1, rlt_pkg::ST_OK, 4'd0);
    plan_cfg(rlt_pkg::CFG_LEVELS, mixed_counts);
    plan_cfg(rlt_pkg::CFG_ENABLE, 40'd1);
    // Error order on a change: untracked domain, then level out of range.
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd3, 4'd0, 64'd10, rlt_pkg::ST_UNTRACKED, 4'd0);
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd1, 4'd1, 64'd20, rlt_pkg::ST_RANGE, 4'd0);
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd0, 4'd15, 64'd100, rlt_pkg::ST_OK, 4'd15);
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd0, 4'd0, 64'd250, rlt_pkg::ST_OK, 4'd0);
    plan_req(rlt_pkg::MODE_READ, 3'd0, 4'd15, 64'd0);
    plan_req(rlt_pkg::MODE_READ, 3'd0, 4'd0, 64'd0);
    // Largest timestamp, then one far behind it so the difference wraps.
    plan_req(rlt_pkg::MODE_CHANGE, 3'd2, 4'd15, '1);
    plan_req(rlt_pkg::MODE_CHANGE, 3'd2, 4'd3, 64'd5);
    plan_req(rlt_pkg::MODE_TICK, 3'd2, 4'd0, '1);
    plan_req(rlt_pkg::MODE_READ, 3'd2, 4'd15, 64'd0);
    plan_fixed(rlt_pkg::MODE_READ, 3'd1, 4'd15, 64'd0, rlt_pkg::ST_RANGE, 4'd0);
    plan_req(MODE_UNUSED, 3'd2, 4'd9, 64'd77);
    plan_req(rlt_pkg::MODE_CHANGE, 3'd7, 4'd15, 64'd300);
    plan_req(rlt_pkg::MODE_CHANGE, 3'd5, 4'd15, 64'd400);
    // Shrinking the count under a domain: its stored level keeps accruing.
    plan_cfg(rlt_pkg::CFG_LEVELS, narrow_counts);
    plan_req(rlt_pkg::MODE_TICK, 3'd0, 4'd0, 64'd1000);
    plan_fixed(rlt_pkg::MODE_READ, 3'd2, 4'd3, 64'd0, rlt_pkg::ST_RANGE, 4'd3);
    plan_req(rlt_pkg::MODE_CHANGE, 3'd2, 4'd1, 64'd2000);
    plan_cfg(rlt_pkg::CFG_LEVELS, mixed_counts);
    plan_req(rlt_pkg::MODE_READ, 3'd2, 4'd3, 64'd0);
    // Disabled again: changes are refused but reads still return the counters.
    plan_cfg(rlt_pkg::CFG_ENABLE, 40'd0);
    plan_fixed(rlt_pkg::MODE_CHANGE, 3'd0, 4'd1, 64'd3000, rlt_pkg::ST_DISABLED, 4'd0);
    plan_req(rlt_pkg::MODE_READ, 3'd0, 4'd0, 64'd0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.is_cfg) begin
        wait_drained();
        cfg_write(row.idx, row.data);
      end else begin
        issue(row.mode, row.dom, row.lvl, row.now, row.fixed, row.want);
      end
    end

    // Random phases, each under its own setting. The stores carry over between phases.
    clock_us = 64'd5000;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          en = 1'b1;
          counts = '1;
          n_items = 170;
        end
        1: begin
          en = 1'b1;
          counts = random_level_counts();
          n_items = 170;
        end
        2: begin
          en = 1'b0;
          counts = random_level_counts();
          n_items = 120;
        end
        3: begin
          en = 1'b1;
          counts = '0;
          for (k = 0; k < rlt_pkg::DOM_SLOTS; k++) begin
            counts[rlt_pkg::CNT_FIELD_W*k +: rlt_pkg::CNT_FIELD_W] = 5'($urandom_range(1, 3));
          end
          n_items = 170;
        end
        4: begin
          en = 1'b1;
          counts = '0;
          n_items = 60;
        end
        default: begin
          en = 1'b1;
          counts = random_level_counts();
          n_items = 210;
        end
      endcase
      wait_drained();
      cfg_write(rlt_pkg::CFG_LEVELS, counts);
      cfg_write(rlt_pkg::CFG_ENABLE, {{(rlt_pkg::CFG_W-1){1'b0}}, en});
      burst_left = $urandom_range(1, 20);

      for (k = 0; k < n_items; k++) begin
        // Once in the run, hold off until the block has handed back everything.
        if (ph == 1 && k == n_items / 2) begin
          wait_drained();
        end

        r = $urandom_range(0, 99);
        if (r < 50) m = rlt_pkg::MODE_CHANGE;
        else if (r < 65) m = rlt_pkg::MODE_TICK;
        else if (r < 95) m = rlt_pkg::MODE_READ;
        else m = MODE_UNUSED;

        d = 3'($urandom_range(0, 7));
        lim = level_limit(d);
        // Mostly levels the domain accepts, so changes get past the checks.
        if (lim != 0 && $urandom_range(0, 9) < 8) begin
          l = 4'($urandom_range(0, lim - 1));
        end else begin
          l = 4'($urandom_range(0, 15));
        end

        // Time mostly moves forward; now and then it jumps anywhere, runs near the top
        // of the range, or steps back.
        r = $urandom_range(0, 99);
        if (r < 85) clock_us = clock_us + $urandom_range(0, 5000);
        else if (r < 92) clock_us = {$urandom, $urandom};
        else if (r < 96) clock_us = '1 - $urandom_range(0, 3000);
        else clock_us = clock_us - $urandom_range(0, 500);

        issue(m, d, l, clock_us, 1'b0, '0);

        burst_left--;
        if (burst_left == 0) begin
          req_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
        end
      end
    end

    wait_drained();
    if (due_results.size() != 0) begin
      report_mismatch("results never delivered", rlt_pkg::TIME_W'(due_results.size()), '0);
    end

    $display("Covered %0d requests (%0d changes, %0d ticks, %0d reads, %0d unused mode)",
             n_mode[0] + n_mode[1] + n_mode[2] + n_mode[3], n_mode[0], n_mode[1], n_mode[2],
             n_mode[3]);
    $display("under %0d register writes; status mix ok/disabled/untracked/range %0d/%0d/%0d/%0d;",
             settings_written, n_status[0], n_status[1], n_status[2], n_status[3]);
    $display("%0d results compared.", results_checked);
    if (errors == 0) begin
      $display("level_residency_tracker test passed");
    end else begin
      $display("level_residency_tracker test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rlt_pkg.sv
rtl/rlt_ram.sv
rtl/level_residency_tracker.sv
rtl/rlt_checker.sv
verif/tb.sv
